// ===== hdl/ake_pkg.sv =====
// Package with shared constants, types and the S-box function for the key expansion.
`timescale 1ns / 1ps
package ake_pkg;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 6;
    localparam int NK_MAX = 8;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    typedef logic [WORD_W-1:0] word_t;

    // Tap record pairing a cell's word with that word's schedule index.
    typedef struct packed {
        word_t            word;
        logic [IDX_W-1:0] idx;
    } cell_tap_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        begin
            case (a)
                8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
                8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
                8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
                8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
                8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
                8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
                8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
                8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
                8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
                8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
                8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
                8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
                8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
                8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
                8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
                8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
                8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
                8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
                8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
                8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
                8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
                8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
                8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
                8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
                8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
                8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
                8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
                8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
                8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
                8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
                8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
                8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
                8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
                8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
                8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
                8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
                8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
                8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
                8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
                8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
                8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
                8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
                8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
                8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
                8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
                8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
                8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
                8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
                8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
                8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
                8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
                8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
                8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
                8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
                8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
                8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
                8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
                8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
                8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
                8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
                8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
                8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
                8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
                8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
            endcase
            return r;
        end
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction
endpackage

// ===== hdl/aes_key_expansion_top.sv =====
// Top level of the AES key expansion: control, cell chain and output register.
`timescale 1ns / 1ps
// The block accepts one cipher key per transaction and streams out the encryption key schedule,
// one 32-bit word per transaction: 44 words for a 128-bit key, 52 for 192 and 60 for 256, with
// tlast on the final word. Key length is set by the configuration register (0 = 128, 1 = 192,
// 2 or 3 = 256) and must be written only while the block is idle. The key is held in a chain of
// eight word cells; each cycle the oldest word leaves the chain toward the output register and
// a new word, computed by a single shared S-box path, enters at the other end. One schedule word
// therefore leaves per cycle when the output side is ready; a new key is taken once the last
// word has been handed off to the output register.
module aes_key_expansion_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,        // key_length_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,     // key_part_a, key_part_b, key_part_c, key_part_d
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,     // round_word, word_index, 2 zero bits
    output logic         m_axis_tlast      // last_word
);
    import ake_pkg::*;

    logic [1:0]       mode_reg;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;       // index of word at cell 0
    logic [2:0]       pos_reg, pos_next;       // index of the word being generated, modulo Nk
    logic [7:0]       rcon_reg, rcon_next;
    logic             ov_reg;
    word_t            ow_reg;
    logic [IDX_W-1:0] oi_reg;
    logic             ol_reg;

    logic [3:0]       nk;
    logic [IDX_W-1:0] total;
    word_t            cells [NK_MAX];
    word_t            loads [NK_MAX];
    word_t            new_word;
    word_t            oldest;
    logic             load, shift, out_free;

    // Cell 0 is the oldest word; Nk cells are live, the last live one holds the newest word.
    always_comb
    begin
        unique case (mode_reg)
            MODE_128: begin nk = 4'd4; total = 6'd44; end
            MODE_192: begin nk = 4'd6; total = 6'd52; end
            default:  begin nk = 4'd8; total = 6'd60; end
        endcase
    end

    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign load          = s_axis_tvalid && !busy_reg;
    assign shift         = busy_reg && out_free;
    assign oldest        = cells[0];

    // Each 64-bit key part sits in tdata from the lowest bits up; its upper half is the
    // earlier key word.
    always_comb
    begin
        for (int k = 0; k < NK_MAX; k++)
        begin
            loads[k] = s_axis_tdata[64*(k/2) + 32*(1 - (k%2)) +: 32];
        end
    end

    ake_core u_core
    (
        .oldest      (oldest),
        .newest      (cells[nk[2:0] - 3'd1]),
        .group_start (pos_reg == 3'd0),
        .mid_group   (nk == 4'd8 && pos_reg == 3'd4),
        .rcon        (rcon_reg),
        .next_word   (new_word)
    );

    // The word entering a cell is its neighbor's; the last live cell takes the new word.
    genvar g;
    generate
        for (g = 0; g < NK_MAX; g++)
        begin : g_cell
            word_t shin;
            if (g == NK_MAX - 1)
            begin : g_end
                assign shin = new_word;
            end
            else
            begin : g_mid
                assign shin = (4'(g + 1) == nk) ? new_word : cells[g + 1];
            end
            ake_cell u_cell
            (
                .clk       (clk),
                .load      (load),
                .shift     (shift),
                .load_word (loads[g]),
                .shift_in  (shin),
                .word      (cells[g])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        rcon_next = rcon_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            pos_next  = '0;
            rcon_next = 8'h01;
        end
        else if (shift)
        begin
            idx_next = idx_reg + 6'd1;
            pos_next = (4'(pos_reg) + 4'd1 == nk) ? 3'd0 : pos_reg + 3'd1;
            if (pos_reg == 3'd0)
            begin
                rcon_next = rcon_reg[7] ? ((rcon_reg << 1) ^ 8'h1b) : (rcon_reg << 1);
            end
            if (idx_reg + 6'd1 == total)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_128;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            idx_reg  <= '0;
            pos_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            pos_reg  <= pos_next;
            rcon_reg <= rcon_next;
            if (shift)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ow_reg <= oldest;
            oi_reg <= idx_reg;
            ol_reg <= (idx_reg + 6'd1 == total);
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, oi_reg, ow_reg};
    assign m_axis_tlast  = ol_reg;
endmodule

// ===== hdl/ake_cell.sv =====
// One word slot of the key window; takes a key word on load, and its neighbor's word when the window advances.
`timescale 1ns / 1ps
module ake_cell
(
    input  logic           clk,
    input  logic           load,
    input  logic           shift,
    input  ake_pkg::word_t load_word,
    input  ake_pkg::word_t shift_in,
    output ake_pkg::word_t word
);
    import ake_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (load)
        begin
            word_next = load_word;
        end
        else if (shift)
        begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
endmodule

// ===== hdl/ake_core.sv =====
// Word generator: computes the next schedule word from the oldest and newest cells.
`timescale 1ns / 1ps
module ake_core
(
    input  ake_pkg::word_t  oldest,
    input  ake_pkg::word_t  newest,
    input  logic            group_start,
    input  logic            mid_group,
    input  logic [7:0]      rcon,
    output ake_pkg::word_t  next_word
);
    import ake_pkg::*;

    word_t sub_in;
    word_t sub_out;
    word_t temp;

    always_comb
    begin
        sub_in = group_start ? {newest[23:0], newest[31:24]} : newest;
        sub_out = sub_word(sub_in);
        if (group_start)
        begin
            temp = sub_out ^ {rcon, 24'h0};
        end
        else if (mid_group)
        begin
            temp = sub_out;
        end
        else
        begin
            temp = newest;
        end
        next_word = oldest ^ temp;
    end
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the AES key expansion block.
`timescale 1ns / 1ps
module testbench;
    import ake_pkg::*;

    localparam logic [1:0] KEYLEN_256 = 2'd2;
    localparam logic [1:0] KEYLEN_ALT = 2'd3;
    localparam int MAX_ERR_PRINT = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  index;
        logic        last;
    } sched_word_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;     // key_part_a, key_part_b, key_part_c, key_part_d
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;     // round_word, word_index, 2 zero bits
    logic         m_axis_tlast;     // last_word

    logic [255:0] key_queue[$];
    sched_word_t  sched_expected[$];
    logic [1:0]   key_len_mode;
    int           mismatch_count;
    int           burst_left;
    int           gap_left;
    int           stall_phase;
    bit           stall_mode;

    aes_key_expansion_top DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Independent S-box, derived from the GF(2^8) inverse and the affine map.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= x;
            x = x[7] ? ((x << 1) ^ 8'h1b) : (x << 1);
        end
        return p;
    endfunction

    function automatic logic [7:0] subst_byte(input logic [7:0] a);
        logic [7:0] inv;
        logic [7:0] r;
        inv = 8'h00;
        for (int c = 1; c < 256; c++)
            if (gf_mul(a, c[7:0]) == 8'h01)
                inv = c[7:0];
        for (int i = 0; i < 8; i++)
            r[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
                   ^ inv[(i + 7) % 8];
        return r ^ 8'h63;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {subst_byte(w[31:24]), subst_byte(w[23:16]), subst_byte(w[15:8]),
                subst_byte(w[7:0])};
    endfunction

    // Expands one key under the current key length and queues every schedule word.
    task automatic expand_key(input logic [255:0] key);
        logic [31:0] w[60];
        logic [31:0] t;
        logic [7:0]  rc;
        int          nk;
        int          total;
        sched_word_t e;
        nk = (key_len_mode == MODE_128) ? 4 : (key_len_mode == MODE_192) ? 6 : 8;
        total = 28 + 4 * nk;
        // Key part n occupies bits 64n and up; its upper half is the earlier word.
        for (int i = 0; i < 4; i++)
        begin
            w[2 * i]     = key[64 * i + 32 +: 32];
            w[2 * i + 1] = key[64 * i +: 32];
        end
        rc = 8'h01;
        for (int i = nk; i < total; i++)
        begin
            t = w[i - 1];
            if (i % nk == 0)
            begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            else if (nk == 8 && i % nk == 4)
                t = subst_word(t);
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i < total; i++)
        begin
            e.word = w[i];
            e.index = i[5:0];
            e.last = (i == total - 1);
            sched_expected.push_back(e);
        end
    endtask

    // The driver sends keys in bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            expand_key(s_axis_tdata);
            void'(key_queue.pop_front());
        end
        if ((!s_axis_tvalid || s_axis_tready) && rst_n)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (key_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= key_queue[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 4);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // The receiver alternates between running freely and stalling at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 97 == 0)
                stall_mode <= $urandom_range(0, 1);
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // The monitor compares every output transaction with the oldest expected word.
    always @(posedge clk)
    begin
        sched_word_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (sched_expected.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_ERR_PRINT)
                    $display("Unexpected word %h index %0d", m_axis_tdata[31:0],
                             m_axis_tdata[37:32]);
            end
            else
            begin
                e = sched_expected.pop_front();
                if (m_axis_tdata[31:0] !== e.word || m_axis_tdata[37:32] !== e.index
                    || m_axis_tlast !== e.last)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_ERR_PRINT)
                        $display("Mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 e.word, e.index, e.last, m_axis_tdata[31:0],
                                 m_axis_tdata[37:32], m_axis_tlast);
                end
            end
        end
    end

    function automatic logic [255:0] random_key();
        logic [255:0] k;
        for (int i = 0; i < 8; i++)
            k[32 * i +: 32] = $urandom;
        return k;
    endfunction

    // Packs the four key parts into one input transaction, part a in the lowest bits.
    function automatic logic [255:0] pack_key(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c, input logic [63:0] d);
        return {d, c, b, a};
    endfunction

    // Lets the queued keys drain and the block settle before the next register write.
    task automatic drain_and_set(input logic [1:0] mode);
        while (key_queue.size() > 0 || s_axis_tvalid || sched_expected.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        key_len_mode = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [1:0] modes[5];
        mismatch_count = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        stall_mode = 1'b0;
        key_len_mode = MODE_128;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = MODE_128;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys under the reset length: the standard test key, all zeros and all ones.
        key_queue.push_back(pack_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                                     64'h0, 64'h0));
        key_queue.push_back('0);
        key_queue.push_back('1);
        // Unused key parts must not affect the 128-bit schedule.
        key_queue.push_back(pack_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                     '1, '1));
        drain_and_set(MODE_192);
        key_queue.push_back(pack_key(64'h8e73b0f7da0e6452, 64'hc810f32b809079e5,
                                     64'h62f8ead2522c6b7b, 64'h0));
        key_queue.push_back('1);
        key_queue.push_back(pack_key(64'h0, 64'h0, 64'h0, 64'hffffffffffffffff));
        drain_and_set(KEYLEN_256);
        key_queue.push_back(pack_key(64'h603deb1015ca71be, 64'h2b73aef0857d7781,
                                     64'h1f352c073b6108d7, 64'h2d9810a30914dff4));
        key_queue.push_back('0);
        key_queue.push_back('1);
        // The undefined length code behaves as a 256-bit key.
        drain_and_set(KEYLEN_ALT);
        key_queue.push_back(pack_key(64'h603deb1015ca71be, 64'h2b73aef0857d7781,
                                     64'h1f352c073b6108d7, 64'h2d9810a30914dff4));
        key_queue.push_back(random_key());

        modes = '{MODE_128, MODE_192, KEYLEN_256, KEYLEN_ALT, MODE_128};
        for (int p = 0; p < 5; p++)
        begin
            drain_and_set(modes[p]);
            for (int n = 0; n < 20; n++)
                key_queue.push_back(random_key());
        end
        while (key_queue.size() > 0 || s_axis_tvalid || sched_expected.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && sched_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
